[hdl/annexb_nal_unit_framer_core_macros.svh]
// Assertion macros for the Annex B framer.
// Simulation gets the checks; synthesis sees empty bodies.
`ifndef ANNEXB_NAL_UNIT_FRAMER_CORE_MACROS_SVH
`define ANNEXB_NAL_UNIT_FRAMER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// prop must hold at every edge out of reset
`define ANBF_ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("anbf: invariant violated");

// trig at one edge implies cons at the same edge
`define ANBF_ASSERT_IMPLY(label, clk, rst_n, trig, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
        else $error("anbf: implication violated");

`else

`define ANBF_ASSERT_ALWAYS(label, clk, rst_n, prop)
`define ANBF_ASSERT_IMPLY(label, clk, rst_n, trig, cons)

`endif

`endif

[hdl/anbf_pkg.sv]
package anbf_pkg;

    typedef enum logic [1:0] {
        MODE_SEARCH = 2'd0,   // hunting for the leading 00 00 00 01
        MODE_GAP    = 2'd1,   // between units, hunting for 00 00 01
        MODE_NAL    = 2'd2    // inside a unit
    } mode_t;

    localparam int MAX_RESULTS = 3;
    localparam int FIFO_DEPTH  = 8;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

    localparam logic [7:0] BYTE_ZERO  = 8'h00;
    localparam logic [7:0] BYTE_ONE   = 8'h01;
    localparam logic [1:0] ZERO_SAT   = 2'd3;
    localparam logic [1:0] ZERO_HELD  = 2'd2;

    typedef struct packed {
        logic [7:0] nal_byte;
        logic       first_of_nal;
        logic       last_of_nal;
        logic       last_of_run;
    } result_t;

    // results produced by one input word, slot 0 first
    typedef struct packed {
        logic [1:0]                    count;
        result_t [MAX_RESULTS-1:0]     res;
    } push_t;

    typedef struct packed {
        logic [FIFO_AW:0] count;
        logic             space_ok;   // room for a full burst
    } fifo_stat_t;

endpackage

[hdl/anbf_framer.sv]
module anbf_framer (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [7:0]       stream_byte,
    input  logic             end_of_stream,
    input  logic             space_ok,
    output anbf_pkg::push_t  push,
    output logic             fire
);
    import anbf_pkg::*;

    // input register
    logic       s1_valid_reg, s1_valid_next;
    logic [7:0] s1_byte_reg;
    logic       s1_eos_reg;

    // framing state
    mode_t      mode_reg, mode_next;
    logic [1:0] zero_reg, zero_next;
    logic [7:0] held_byte_reg, held_byte_next;
    logic       held_valid_reg, held_valid_next;
    logic       nif_reg, nif_next;

    logic [1:0] zr;
    logic [1:0] cnt;
    logic       close;
    logic       accept;

    assign fire     = s1_valid_reg && space_ok;
    assign in_ready = !s1_valid_reg || fire;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        if (accept)
            s1_valid_next = 1'b1;
        else if (fire)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_byte_reg <= stream_byte;
            s1_eos_reg  <= end_of_stream;
        end
    end

    // next state and emitted count for the word in the input register
    always_comb
    begin
        mode_next       = mode_reg;
        zero_next       = zero_reg;
        held_byte_next  = held_byte_reg;
        held_valid_next = held_valid_reg;
        nif_next        = nif_reg;
        cnt             = 2'd0;
        close           = 1'b0;
        zr              = (zero_reg > ZERO_HELD) ? ZERO_HELD : zero_reg;

        if (s1_eos_reg)
        begin
            // flush held byte and held zeros
            if (mode_reg == MODE_NAL)
            begin
                cnt   = {1'b0, held_valid_reg} + zr;
                close = 1'b1;
            end
            mode_next       = MODE_SEARCH;
            zero_next       = 2'd0;
            held_byte_next  = BYTE_ZERO;
            held_valid_next = 1'b0;
            nif_next        = 1'b0;
        end
        else
        begin
            unique case (mode_reg)
                MODE_NAL:
                begin
                    priority if (s1_byte_reg == BYTE_ZERO && zr == ZERO_HELD)
                    begin
                        // 00 00 00 ends the unit
                        cnt             = {1'b0, held_valid_reg};
                        close           = 1'b1;
                        held_valid_next = 1'b0;
                        held_byte_next  = BYTE_ZERO;
                        nif_next        = 1'b0;
                        mode_next       = MODE_GAP;
                        zero_next       = ZERO_SAT;
                    end
                    else if (s1_byte_reg == BYTE_ZERO)
                    begin
                        zero_next = zr + 2'd1;
                    end
                    else if (s1_byte_reg == BYTE_ONE && zr == ZERO_HELD)
                    begin
                        // 00 00 01 ends this unit and opens the next
                        cnt             = {1'b0, held_valid_reg};
                        close           = 1'b1;
                        held_valid_next = 1'b0;
                        held_byte_next  = BYTE_ZERO;
                        nif_next        = 1'b1;
                        zero_next       = 2'd0;
                    end
                    else
                    begin
                        // payload: release held byte and held zeros
                        cnt             = {1'b0, held_valid_reg} + zr;
                        held_byte_next  = s1_byte_reg;
                        held_valid_next = 1'b1;
                        zero_next       = 2'd0;
                        if (cnt != 2'd0)
                            nif_next = 1'b0;
                    end
                end
                MODE_GAP:
                begin
                    priority if (s1_byte_reg == BYTE_ZERO)
                    begin
                        zero_next = (zero_reg == ZERO_SAT) ? ZERO_SAT : zero_reg + 2'd1;
                    end
                    else if (s1_byte_reg == BYTE_ONE && zero_reg >= ZERO_HELD)
                    begin
                        mode_next       = MODE_NAL;
                        nif_next        = 1'b1;
                        zero_next       = 2'd0;
                        held_valid_next = 1'b0;
                    end
                    else
                    begin
                        zero_next = 2'd0;
                    end
                end
                default:
                begin
                    priority if (s1_byte_reg == BYTE_ZERO)
                    begin
                        zero_next = (zero_reg == ZERO_SAT) ? ZERO_SAT : zero_reg + 2'd1;
                    end
                    else if (s1_byte_reg == BYTE_ONE && zero_reg == ZERO_SAT)
                    begin
                        mode_next       = MODE_NAL;
                        nif_next        = 1'b1;
                        zero_next       = 2'd0;
                        held_valid_next = 1'b0;
                    end
                    else
                    begin
                        mode_next = MODE_SEARCH;
                        zero_next = 2'd0;
                    end
                end
            endcase
        end
    end

    // result slots: held byte leads, then zeros
    always_comb
    begin
        push.count = fire ? cnt : 2'd0;
        for (int k = 0; k < MAX_RESULTS; k++)
        begin
            push.res[k].nal_byte     = (held_valid_reg && k == 0) ? held_byte_reg : BYTE_ZERO;
            push.res[k].first_of_nal = (k == 0) && nif_reg;
            push.res[k].last_of_run  = (2'(k) == cnt - 2'd1);
            push.res[k].last_of_nal  = close && (2'(k) == cnt - 2'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_SEARCH;
            zero_reg       <= 2'd0;
            held_byte_reg  <= BYTE_ZERO;
            held_valid_reg <= 1'b0;
            nif_reg        <= 1'b0;
        end
        else if (fire)
        begin
            mode_reg       <= mode_next;
            zero_reg       <= zero_next;
            held_byte_reg  <= held_byte_next;
            held_valid_reg <= held_valid_next;
            nif_reg        <= nif_next;
        end
    end

endmodule

[hdl/anbf_fifo.sv]
module anbf_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  anbf_pkg::push_t      push,
    output logic                 out_valid,
    input  logic                 out_ready,
    output anbf_pkg::result_t    head,
    output anbf_pkg::fifo_stat_t stat
);
    import anbf_pkg::*;

    result_t              mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]     count_reg, count_next;
    logic                 pop;

    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && out_ready;
    assign head      = mem_reg[rd_ptr_reg];

    // burst room is judged on the registered count; a same-cycle pop is not credited
    assign stat.count    = count_reg;
    assign stat.space_ok = (count_reg <= (FIFO_AW+1)'(FIFO_DEPTH - MAX_RESULTS));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + FIFO_AW'(push.count);
        rd_ptr_next = rd_ptr_reg + FIFO_AW'(pop);
        count_next  = count_reg + (FIFO_AW+1)'(push.count) - (FIFO_AW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < MAX_RESULTS; k++)
        begin
            if (2'(k) < push.count)
                mem_reg[wr_ptr_reg + FIFO_AW'(k)] <= push.res[k];
        end
    end

endmodule

[hdl/annexb_nal_unit_framer_core.sv]
// Annex B byte-stream NAL unit framer.
// Input channel (in_valid/in_ready): one stream byte per word, with
// end_of_stream marking the end (its byte is ignored, held bytes flush).
// Output channel (out_valid/out_ready): NAL payload bytes with first_of_nal,
// last_of_nal, and last_of_run on the final result of one input word.
// Path: an accepted word is held in the input register, framed and written
// to the result queue when it fires, and appears on the output from there.
// Throughput: one input word per cycle while the queue has burst room. One
// word can release up to three results; the output drains one per cycle
// from an 8-entry queue while out_ready is high, and the input register
// waits while fewer than three queue slots are free.
// Zeros inside a unit give no output until the unit resolves, so bursts
// come after runs of zero bytes.
// Reset: the framer hunts for 00 00 00 01 again, queue empty, no words held.
// Output stall: the queue fills, then the input register holds its word and
// in_ready drops; nothing is lost or repeated.
`include "annexb_nal_unit_framer_core_macros.svh"

module annexb_nal_unit_framer_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] stream_byte,
    input  logic       end_of_stream,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] nal_byte,
    output logic       first_of_nal,
    output logic       last_of_nal,
    output logic       last_of_run
);
    import anbf_pkg::*;

    push_t      push;
    result_t    head;
    fifo_stat_t stat;
    logic       fire;

    anbf_framer u_framer (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .stream_byte   (stream_byte),
        .end_of_stream (end_of_stream),
        .space_ok      (stat.space_ok),
        .push          (push),
        .fire          (fire)
    );

    anbf_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head),
        .stat      (stat)
    );

    assign nal_byte     = head.nal_byte;
    assign first_of_nal = head.first_of_nal;
    assign last_of_nal  = head.last_of_nal;
    assign last_of_run  = head.last_of_run;

    // queue occupancy never exceeds its depth
    `ANBF_ASSERT_ALWAYS(a_count_bound, clk, rst_n, stat.count <= (FIFO_AW+1)'(FIFO_DEPTH))

    // a burst is only written when it fits
    `ANBF_ASSERT_IMPLY(a_push_fits, clk, rst_n, push.count != 2'd0,
        ((FIFO_AW+2)'(stat.count) + (FIFO_AW+2)'(push.count)) <= (FIFO_AW+2)'(FIFO_DEPTH))

    // results are only produced by a framed word
    `ANBF_ASSERT_IMPLY(a_push_needs_fire, clk, rst_n, push.count != 2'd0, fire)

    // with no framed word and no burst room, the input is closed or the queue holds entries
    `ANBF_ASSERT_IMPLY(a_hold_blocks, clk, rst_n, !fire && !stat.space_ok, !in_ready || !out_valid || stat.count != '0)

endmodule

[test/annexb_nal_unit_framer_core_tb.sv]
module annexb_nal_unit_framer_core_tb;

    import anbf_pkg::*;

    // One stimulus word. Directed rows may carry a typed-in expectation
    // (typed = 1, n results, n is 0 or 1); all other words are checked
    // against the framing model below. hold makes the sender wait for the
    // output side to drain completely before offering this word.
    typedef struct {
        logic [7:0] data;
        logic       eos;
        bit         typed;
        int         n;
        result_t    r;
        bit         hold;
    } stim_word_t;

    localparam int DIR_ROWS     = 27;
    localparam int RANDOM_WORDS = 240;

    // Directed walk: search noise, the four-byte start code, a unit that
    // releases a held zero, close by 00 00 01, an empty unit, a one-byte
    // unit closed by 00 00 00, gap zeros, reopen, zeros flushed at end of
    // stream, and end of stream outside a unit.
    stim_word_t directed [DIR_ROWS] = '{
        '{8'h00, 1'b0, 1'b1, 0, '0, 1'b0},                          // search, one zero
        '{8'h01, 1'b0, 1'b1, 0, '0, 1'b0},                          // 01 after one zero: no sync
        '{8'h00, 1'b0, 1'b1, 0, '0, 1'b0},
        '{8'h00, 1'b0, 1'b1, 0, '0, 1'b0},
        '{8'h00, 1'b0, 1'b1, 0, '0, 1'b0},
        '{8'h01, 1'b0, 1'b1, 0, '0, 1'b0},                          // 00 00 00 01: unit opens
        '{8'hFF, 1'b0, 1'b1, 0, '0, 1'b0},                          // delayed, nothing out yet
        '{8'h00, 1'b0, 1'b1, 0, '0, 1'b0},                          // zero held back
        '{8'h80, 1'b0, 1'b0, 0, '0, 1'b0},                          // releases FF and the zero
        '{8'h00, 1'b0, 1'b1, 0, '0, 1'b0},
        '{8'h00, 1'b0, 1'b1, 0, '0, 1'b0},
        '{8'h01, 1'b0, 1'b1, 1, '{8'h80, 1'b0, 1'b1, 1'b1}, 1'b0},  // 00 00 01 closes
        '{8'h00, 1'b0, 1'b1, 0, '0, 1'b0},
        '{8'h00, 1'b0, 1'b1, 0, '0, 1'b0},
        '{8'h01, 1'b0, 1'b1, 0, '0, 1'b0},                          // empty unit: silent
        '{8'h01, 1'b0, 1'b1, 0, '0, 1'b0},                          // one-byte payload
        '{8'h00, 1'b0, 1'b1, 0, '0, 1'b0},
        '{8'h00, 1'b0, 1'b1, 0, '0, 1'b0},
        '{8'h00, 1'b0, 1'b1, 1, '{8'h01, 1'b1, 1'b1, 1'b1}, 1'b0},  // 00 00 00 closes
        '{8'h00, 1'b0, 1'b1, 0, '0, 1'b0},                          // gap zero count saturates
        '{8'h00, 1'b0, 1'b1, 0, '0, 1'b0},
        '{8'h01, 1'b0, 1'b1, 0, '0, 1'b0},                          // reopen from gap
        '{8'hAB, 1'b0, 1'b1, 0, '0, 1'b0},
        '{8'h00, 1'b0, 1'b1, 0, '0, 1'b0},
        '{8'h00, 1'b0, 1'b1, 0, '0, 1'b0},
        '{8'hFF, 1'b1, 1'b0, 0, '0, 1'b0},                          // eos: AB 00 00 flushed
        '{8'h5A, 1'b1, 1'b1, 0, '0, 1'b0}                           // eos outside a unit
    };

    logic       clk;
    logic       rst_n         = 1'b0;
    logic       in_valid      = 1'b0;
    logic       in_ready;
    logic [7:0] stream_byte   = 8'h00;
    logic       end_of_stream = 1'b0;
    logic       out_valid;
    logic       out_ready     = 1'b0;
    logic [7:0] nal_byte;
    logic       first_of_nal;
    logic       last_of_nal;
    logic       last_of_run;

    stim_word_t stim[$];
    result_t    nal_expect_q[$];    // payload bytes still owed by the block
    result_t    burst[$];           // bytes released by the last framed word
    result_t    want;

    // framing model state
    mode_t      fr_mode;
    logic [1:0] fr_zeros;
    logic [7:0] fr_held;
    bit         fr_held_v;
    bit         fr_first;

    int         send_idx  = 0;      // next word to offer
    int         acc_idx   = 0;      // words accepted so far
    int         errors    = 0;
    int         hold_left = 0;
    bit         hold_done = 0;
    logic       no_idle;

    // steady stretch with neither side idling
    assign no_idle = (acc_idx >= DIR_ROWS + 160) && (acc_idx < DIR_ROWS + 230);

    annexb_nal_unit_framer_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .stream_byte  (stream_byte),
        .end_of_stream(end_of_stream),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .nal_byte     (nal_byte),
        .first_of_nal (first_of_nal),
        .last_of_nal  (last_of_nal),
        .last_of_run  (last_of_run)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

    task automatic add_word(input logic [7:0] data, input logic eos, input bit hold);
        stim_word_t w;
        w.data  = data;
        w.eos   = eos;
        w.typed = 1'b0;
        w.n     = 0;
        w.r     = '0;
        w.hold  = hold;
        stim.push_back(w);
    endtask

    // Payload bytes lean on 00, 01 and FF so terminators and held zeros
    // turn up often inside units.
    function automatic logic [7:0] payload_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25)
            return BYTE_ZERO;
        if (r < 35)
            return BYTE_ONE;
        if (r < 42)
            return 8'hFF;
        return 8'($urandom);
    endfunction

    task automatic release_byte(input logic [7:0] data, input bit last);
        result_t r;
        r.nal_byte     = data;
        r.first_of_nal = fr_first;
        r.last_of_nal  = last;
        r.last_of_run  = 1'b0;
        fr_first       = 1'b0;
        burst.push_back(r);
    endtask

    // Frame one stream word; results land in burst.
    task automatic frame_word(input logic [7:0] b, input logic eos);
        logic [1:0] zr;
        int         i;
        burst.delete();
        zr = (fr_zeros > ZERO_HELD) ? ZERO_HELD : fr_zeros;
        if (eos)
        begin
            if (fr_mode == MODE_NAL)
            begin
                // held zeros come out as payload; the final byte closes the unit
                if (fr_held_v)
                    release_byte(fr_held, zr == 2'd0);
                for (i = 0; i < zr; i++)
                    release_byte(BYTE_ZERO, i + 1 == zr);
            end
            fr_mode   = MODE_SEARCH;
            fr_zeros  = '0;
            fr_held   = '0;
            fr_held_v = 1'b0;
            fr_first  = 1'b0;
        end
        else
        begin
            case (fr_mode)
                MODE_NAL:
                begin
                    if (b == BYTE_ZERO && zr == ZERO_HELD)
                    begin
                        if (fr_held_v)
                            release_byte(fr_held, 1'b1);
                        fr_held_v = 1'b0;
                        fr_held   = '0;
                        fr_first  = 1'b0;
                        fr_mode   = MODE_GAP;
                        fr_zeros  = ZERO_SAT;
                    end
                    else if (b == BYTE_ZERO)
                        fr_zeros = zr + 2'd1;
                    else if (b == BYTE_ONE && zr == ZERO_HELD)
                    begin
                        // close this unit and open the next
                        if (fr_held_v)
                            release_byte(fr_held, 1'b1);
                        fr_held_v = 1'b0;
                        fr_held   = '0;
                        fr_first  = 1'b1;
                        fr_zeros  = '0;
                    end
                    else
                    begin
                        if (fr_held_v)
                            release_byte(fr_held, 1'b0);
                        for (i = 0; i < zr; i++)
                            release_byte(BYTE_ZERO, 1'b0);
                        fr_held   = b;
                        fr_held_v = 1'b1;
                        fr_zeros  = '0;
                    end
                end
                MODE_GAP:
                begin
                    if (b == BYTE_ZERO)
                        fr_zeros = (fr_zeros == ZERO_SAT) ? ZERO_SAT : fr_zeros + 2'd1;
                    else if (b == BYTE_ONE && fr_zeros >= ZERO_HELD)
                    begin
                        fr_mode   = MODE_NAL;
                        fr_first  = 1'b1;
                        fr_zeros  = '0;
                        fr_held_v = 1'b0;
                    end
                    else
                        fr_zeros = '0;
                end
                default:
                begin
                    // initial sync needs three zeros before the 01
                    if (b == BYTE_ZERO)
                        fr_zeros = (fr_zeros == ZERO_SAT) ? ZERO_SAT : fr_zeros + 2'd1;
                    else if (b == BYTE_ONE && fr_zeros >= ZERO_SAT)
                    begin
                        fr_mode   = MODE_NAL;
                        fr_first  = 1'b1;
                        fr_zeros  = '0;
                        fr_held_v = 1'b0;
                    end
                    else
                    begin
                        fr_mode  = MODE_SEARCH;
                        fr_zeros = '0;
                    end
                end
            endcase
        end
        if (burst.size() > 0)
            burst[burst.size() - 1].last_of_run = 1'b1;
    endtask

    // Sender: offers words in order, idles at random, holds valid and the
    // payload steady while the block stalls, and frames each word as it is
    // accepted.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                frame_word(stream_byte, end_of_stream);
                if (stim[acc_idx].typed)
                begin
                    if (stim[acc_idx].n == 1)
                        nal_expect_q.push_back(stim[acc_idx].r);
                end
                else
                begin
                    foreach (burst[k])
                        nal_expect_q.push_back(burst[k]);
                end
                acc_idx++;
            end
            if (!(in_valid && !in_ready))
            begin
                if (send_idx < stim.size()
                    && !(stim[send_idx].hold
                         && (acc_idx != send_idx || nal_expect_q.size() != 0))
                    && (no_idle || $urandom_range(0, 99) >= 18))
                begin
                    in_valid      <= 1'b1;
                    stream_byte   <= stim[send_idx].data;
                    end_of_stream <= stim[send_idx].eos;
                    send_idx++;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver: checks each byte against the oldest expectation; once it
    // stops taking bytes for a long stretch so the queue fills and the
    // input stalls.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (nal_expect_q.size() == 0)
                begin
                    $error("unexpected result: nal_byte %h", nal_byte);
                    errors++;
                end
                else
                begin
                    want = nal_expect_q.pop_front();
                    if (nal_byte !== want.nal_byte)
                    begin
                        $error("nal_byte: expected %h, got %h", want.nal_byte, nal_byte);
                        errors++;
                    end
                    if (first_of_nal !== want.first_of_nal)
                    begin
                        $error("first_of_nal: expected %b, got %b",
                               want.first_of_nal, first_of_nal);
                        errors++;
                    end
                    if (last_of_nal !== want.last_of_nal)
                    begin
                        $error("last_of_nal: expected %b, got %b",
                               want.last_of_nal, last_of_nal);
                        errors++;
                    end
                    if (last_of_run !== want.last_of_run)
                    begin
                        $error("last_of_run: expected %b, got %b",
                               want.last_of_run, last_of_run);
                        errors++;
                    end
                end
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else if (!hold_done && acc_idx >= DIR_ROWS + 100)
            begin
                hold_done = 1'b1;
                hold_left = 100;
                out_ready <= 1'b0;
            end
            else
                out_ready <= no_idle || ($urandom_range(0, 99) >= 18);
        end
    end

    initial
    begin
        int         stream_no;
        int         units;
        int         plen;
        int         u;

        fr_mode   = MODE_SEARCH;
        fr_zeros  = '0;
        fr_held   = '0;
        fr_held_v = 1'b0;
        fr_first  = 1'b0;

        foreach (directed[i])
            stim.push_back(directed[i]);

        // Random part: mostly well-formed streams with random payload, plus
        // noise before sync, junk in gaps and broken prefixes.
        stream_no = 0;
        while (stim.size() < DIR_ROWS + RANDOM_WORDS)
        begin
            stream_no++;
            repeat ($urandom_range(0, 2))
                add_word(8'($urandom), 1'b0, 1'b0);
            // some streams start only after all output has drained
            add_word(BYTE_ZERO, 1'b0, (stream_no % 4) == 2);
            add_word(BYTE_ZERO, 1'b0, 1'b0);
            add_word(BYTE_ZERO, 1'b0, 1'b0);
            add_word(BYTE_ONE, 1'b0, 1'b0);
            units = $urandom_range(1, 4);
            for (u = 0; u < units; u++)
            begin
                plen = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
                repeat (plen)
                    add_word(payload_byte(), 1'b0, 1'b0);
                if (u != units - 1)
                begin
                    case ($urandom_range(0, 3))
                        0, 1:
                        begin
                            add_word(BYTE_ZERO, 1'b0, 1'b0);
                            add_word(BYTE_ZERO, 1'b0, 1'b0);
                        end
                        2:
                        begin
                            // close by 00 00 00, trailing zeros, maybe junk
                            repeat (3 + $urandom_range(0, 2))
                                add_word(BYTE_ZERO, 1'b0, 1'b0);
                            if ($urandom_range(0, 1))
                                add_word(8'($urandom_range(2, 255)), 1'b0, 1'b0);
                            add_word(BYTE_ZERO, 1'b0, 1'b0);
                            add_word(BYTE_ZERO, 1'b0, 1'b0);
                        end
                        default:
                        begin
                            // gap with a short 00 01 that must not open a unit
                            repeat (3)
                                add_word(BYTE_ZERO, 1'b0, 1'b0);
                            add_word(8'($urandom_range(2, 255)), 1'b0, 1'b0);
                            add_word(BYTE_ZERO, 1'b0, 1'b0);
                            add_word(BYTE_ONE, 1'b0, 1'b0);
                            add_word(BYTE_ZERO, 1'b0, 1'b0);
                            add_word(BYTE_ZERO, 1'b0, 1'b0);
                        end
                    endcase
                    add_word(BYTE_ONE, 1'b0, 1'b0);
                end
            end
            // tail: trailing zeros after a close, or held zeros at eos
            case ($urandom_range(0, 3))
                0: repeat (3 + $urandom_range(0, 1)) add_word(BYTE_ZERO, 1'b0, 1'b0);
                1: repeat ($urandom_range(1, 2)) add_word(BYTE_ZERO, 1'b0, 1'b0);
                default: ;
            endcase
            add_word(8'($urandom), 1'b1, 1'b0);
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (acc_idx != stim.size())
            @(posedge clk);
        while (nal_expect_q.size() != 0)
            @(posedge clk);
        // nothing more may come out after the last owed byte
        repeat (10) @(posedge clk);

        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
